// ===== design/rtch_pkg.sv =====
// Shared types, constants and the multiply-accumulate program for the closest-hit block.
package rtch_pkg;

   localparam int COORD_W    = 32;
   localparam int NORMAL_W   = 16;
   localparam int EPS_W      = 16;
   localparam int IDX_W      = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int ACC_W      = 66;
   localparam int DIVD_W     = 48;
   localparam int FRAC       = 16;
   localparam int NFRAC      = NORMAL_W - 2;
   localparam int PC_W       = 6;
   localparam int CNT_W      = 6;

   localparam logic [CNT_W-1:0] DIV_STEPS  = CNT_W'(DIVD_W);
   localparam logic [CNT_W-1:0] SQRT_STEPS = CNT_W'(32);

   localparam logic signed [COORD_W-1:0] CMAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam logic signed [COORD_W-1:0] CMIN = {1'b1, {(COORD_W-1){1'b0}}};
   localparam logic signed [COORD_W-1:0] ONE_Q = COORD_W'(65536);
   localparam logic signed [COORD_W-1:0] DIR_Z_RESET = COORD_W'(65536);
   localparam logic [EPS_W-1:0] EPS_RESET = EPS_W'(1);
   localparam logic [IDX_W-1:0] IDX_TOP = {IDX_W{1'b1}};

   // register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_Z    = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON  = 3'd6;

   // program segment starts
   localparam logic [PC_W-1:0] PC_SEG_A = 6'd0;
   localparam logic [PC_W-1:0] PC_SEG_B = 6'd9;
   localparam logic [PC_W-1:0] PC_SEG_C = 6'd12;
   localparam logic [PC_W-1:0] PC_SEG_D = 6'd21;
   localparam logic [PC_W-1:0] PC_SEG_E = 6'd24;
   localparam logic [PC_W-1:0] PC_SEG_F = 6'd33;
   localparam logic [PC_W-1:0] PC_SEG_G = 6'd36;
   localparam logic [PC_W-1:0] PC_END   = 6'd39;

   typedef struct packed {
      logic signed [COORD_W-1:0] vert0_x;
      logic signed [COORD_W-1:0] vert0_y;
      logic signed [COORD_W-1:0] vert0_z;
      logic signed [COORD_W-1:0] vert1_x;
      logic signed [COORD_W-1:0] vert1_y;
      logic signed [COORD_W-1:0] vert1_z;
      logic signed [COORD_W-1:0] vert2_x;
      logic signed [COORD_W-1:0] vert2_y;
      logic signed [COORD_W-1:0] vert2_z;
      logic                      last_triangle;
   } req_word_type;

   typedef struct packed {
      logic                       found;
      logic [COORD_W-2:0]         hit_t;
      logic signed [COORD_W-1:0]  hit_point_x;
      logic signed [COORD_W-1:0]  hit_point_y;
      logic signed [COORD_W-1:0]  hit_point_z;
      logic signed [NORMAL_W-1:0] normal_x;
      logic signed [NORMAL_W-1:0] normal_y;
      logic signed [NORMAL_W-1:0] normal_z;
      logic [IDX_W-1:0]           hit_index;
   } rsp_word_type;

   typedef enum logic [4:0] {
      OPD_D0, OPD_D1, OPD_D2,
      OPD_EA0, OPD_EA1, OPD_EA2,
      OPD_EB0, OPD_EB1, OPD_EB2,
      OPD_S0, OPD_S1, OPD_S2,
      OPD_H0, OPD_H1, OPD_H2,
      OPD_Q0, OPD_Q1, OPD_Q2,
      OPD_T,
      OPD_M0, OPD_M1, OPD_M2,
      OPD_NN0, OPD_NN1, OPD_NN2
   } opnd_type;

   typedef enum logic [4:0] {
      DST_NONE,
      DST_H0, DST_H1, DST_H2,
      DST_DET, DST_TMP,
      DST_Q0, DST_Q1, DST_Q2,
      DST_N0, DST_N1, DST_N2,
      DST_P0, DST_P1, DST_P2,
      DST_SQ, DST_SGN
   } dst_type;

   typedef struct packed {
      opnd_type a;
      opnd_type b;
      logic     neg;
      logic     first;
      logic     last;
      logic     brk;
      logic     raw;
      dst_type  dst;
   } step_type;

   function automatic step_type stp(input opnd_type a, input opnd_type b, input logic neg,
                                    input logic first, input logic last, input logic brk,
                                    input logic raw, input dst_type dst);
      step_type s;
      s.a = a; s.b = b; s.neg = neg; s.first = first;
      s.last = last; s.brk = brk; s.raw = raw; s.dst = dst;
      return s;
   endfunction

   // one multiply-accumulate per entry; brk ends a segment
   function automatic step_type prog_step(input logic [PC_W-1:0] pc);
      step_type s;
      case (pc)
         6'd0:  s = stp(OPD_D1, OPD_EB2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd1:  s = stp(OPD_D2, OPD_EB1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_H0);
         6'd2:  s = stp(OPD_D2, OPD_EB0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd3:  s = stp(OPD_D0, OPD_EB2, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_H1);
         6'd4:  s = stp(OPD_D0, OPD_EB1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd5:  s = stp(OPD_D1, OPD_EB0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_H2);
         6'd6:  s = stp(OPD_EA0, OPD_H0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd7:  s = stp(OPD_EA1, OPD_H1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd8:  s = stp(OPD_EA2, OPD_H2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, DST_DET);
         6'd9:  s = stp(OPD_S0, OPD_H0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd10: s = stp(OPD_S1, OPD_H1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd11: s = stp(OPD_S2, OPD_H2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, DST_TMP);
         6'd12: s = stp(OPD_S1, OPD_EA2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd13: s = stp(OPD_S2, OPD_EA1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_Q0);
         6'd14: s = stp(OPD_S2, OPD_EA0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd15: s = stp(OPD_S0, OPD_EA2, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_Q1);
         6'd16: s = stp(OPD_S0, OPD_EA1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd17: s = stp(OPD_S1, OPD_EA0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_Q2);
         6'd18: s = stp(OPD_D0, OPD_Q0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd19: s = stp(OPD_D1, OPD_Q1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd20: s = stp(OPD_D2, OPD_Q2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, DST_TMP);
         6'd21: s = stp(OPD_EB0, OPD_Q0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd22: s = stp(OPD_EB1, OPD_Q1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd23: s = stp(OPD_EB2, OPD_Q2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, DST_TMP);
         6'd24: s = stp(OPD_EA1, OPD_EB2, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd25: s = stp(OPD_EA2, OPD_EB1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_N0);
         6'd26: s = stp(OPD_EA2, OPD_EB0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd27: s = stp(OPD_EA0, OPD_EB2, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_N1);
         6'd28: s = stp(OPD_EA0, OPD_EB1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd29: s = stp(OPD_EA1, OPD_EB0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, DST_N2);
         6'd30: s = stp(OPD_T, OPD_D0, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_P0);
         6'd31: s = stp(OPD_T, OPD_D1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, DST_P1);
         6'd32: s = stp(OPD_T, OPD_D2, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, DST_P2);
         6'd33: s = stp(OPD_M0, OPD_M0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd34: s = stp(OPD_M1, OPD_M1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, DST_NONE);
         6'd35: s = stp(OPD_M2, OPD_M2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, DST_SQ);
         6'd36: s = stp(OPD_NN0, OPD_D0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd37: s = stp(OPD_NN1, OPD_D1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE);
         6'd38: s = stp(OPD_NN2, OPD_D2, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0, DST_SGN);
         default: s = stp(OPD_D0, OPD_D0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE);
      endcase
      return s;
   endfunction

endpackage

// ===== design/ray_triangle_closest_hit.sv =====
// Closest-hit ray/triangle test: sequencer around one multiplier, divider and square root.
// One triangle at a time; req_stall stays high while a triangle is in work.
// A triangle rejected by the determinant, u, v or t finishes sooner than a new nearest hit,
// which is dominated by the 48-step restoring divider (up to six runs per hit) and the
// 32-step square root.
// The result word sits in an output register, so the next triangle is taken while it waits.
// Synchronous reset loads the register defaults and clears the running best and index.
module ray_triangle_closest_hit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  rtch_pkg::req_word_type             req_word,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output rtch_pkg::rsp_word_type             rsp_word,
   input  logic                               csr_wr_en,
   input  logic [rtch_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [rtch_pkg::COORD_W-1:0]       csr_wdata
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_MAC, ST_WAIT, ST_CHK_DET, ST_DIV_LOAD, ST_DIV_RUN, ST_DIV_DONE,
      ST_NRM, ST_SQ_LOAD, ST_SQ_RUN, ST_SQ_DONE, ST_COMMIT, ST_FINISH
   } state_type;

   typedef enum logic [2:0] {DK_U, DK_V, DK_T, DK_N0, DK_N1, DK_N2} dkind_type;

   state_type state_ff;
   dkind_type dkind_ff;
   logic [rtch_pkg::PC_W-1:0]  pc_ff;
   logic [rtch_pkg::CNT_W-1:0] cnt_ff;

   logic signed [31:0] o_ff [3];
   logic signed [31:0] d_ff [3];
   logic [15:0]        eps_ff;

   logic signed [31:0] ea_ff [3];
   logic signed [31:0] eb_ff [3];
   logic signed [31:0] s_ff  [3];
   logic signed [31:0] h_ff  [3];
   logic signed [31:0] q_ff  [3];
   logic signed [31:0] n_ff  [3];
   logic signed [31:0] p_ff  [3];
   logic [30:0]        m_ff  [3];
   logic signed [15:0] nn_ff [3];
   logic signed [31:0] det_ff, tmp_ff, u_ff, t_ff;
   logic [63:0]        sq_ff;
   logic               sgn_ff;
   logic               last_ff;

   logic signed [rtch_pkg::ACC_W-1:0] prod_ff, acc_ff;
   rtch_pkg::step_type ctl_ff;
   logic               ctl_vld_ff;

   logic [47:0] dvd_ff;
   logic [31:0] rem_ff, dsr_ff, len_ff;
   logic        dneg_ff;
   logic [63:0] sx_ff, sres_ff, sbit_ff;

   logic               best_found_ff;
   logic [30:0]        best_t_ff;
   logic signed [31:0] best_p_ff [3];
   logic signed [15:0] best_n_ff [3];
   logic [15:0]        best_idx_ff;
   logic [15:0]        tri_cnt_ff;

   logic                   rsp_valid_ff;
   rtch_pkg::rsp_word_type rsp_word_ff;

   function automatic logic [31:0] magn(input logic signed [31:0] x);
      return x[31] ? 32'(-x) : 32'(x);
   endfunction

   function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] diff;
      diff = 33'(a) - 33'(b);
      if (diff[32] != diff[31]) begin
         return diff[32] ? rtch_pkg::CMIN : rtch_pkg::CMAX;
      end
      return diff[31:0];
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [rtch_pkg::ACC_W-1:0] x);
      if (!x[rtch_pkg::ACC_W-1] && (|x[rtch_pkg::ACC_W-2:31])) begin
         return rtch_pkg::CMAX;
      end
      if (x[rtch_pkg::ACC_W-1] && !(&x[rtch_pkg::ACC_W-2:31])) begin
         return rtch_pkg::CMIN;
      end
      return x[31:0];
   endfunction

   function automatic logic signed [31:0] pick(input rtch_pkg::opnd_type sel);
      logic signed [31:0] r;
      case (sel)
         rtch_pkg::OPD_D0:  r = d_ff[0];
         rtch_pkg::OPD_D1:  r = d_ff[1];
         rtch_pkg::OPD_D2:  r = d_ff[2];
         rtch_pkg::OPD_EA0: r = ea_ff[0];
         rtch_pkg::OPD_EA1: r = ea_ff[1];
         rtch_pkg::OPD_EA2: r = ea_ff[2];
         rtch_pkg::OPD_EB0: r = eb_ff[0];
         rtch_pkg::OPD_EB1: r = eb_ff[1];
         rtch_pkg::OPD_EB2: r = eb_ff[2];
         rtch_pkg::OPD_S0:  r = s_ff[0];
         rtch_pkg::OPD_S1:  r = s_ff[1];
         rtch_pkg::OPD_S2:  r = s_ff[2];
         rtch_pkg::OPD_H0:  r = h_ff[0];
         rtch_pkg::OPD_H1:  r = h_ff[1];
         rtch_pkg::OPD_H2:  r = h_ff[2];
         rtch_pkg::OPD_Q0:  r = q_ff[0];
         rtch_pkg::OPD_Q1:  r = q_ff[1];
         rtch_pkg::OPD_Q2:  r = q_ff[2];
         rtch_pkg::OPD_T:   r = t_ff;
         rtch_pkg::OPD_M0:  r = {1'b0, m_ff[0]};
         rtch_pkg::OPD_M1:  r = {1'b0, m_ff[1]};
         rtch_pkg::OPD_M2:  r = {1'b0, m_ff[2]};
         rtch_pkg::OPD_NN0: r = 32'(nn_ff[0]);
         rtch_pkg::OPD_NN1: r = 32'(nn_ff[1]);
         rtch_pkg::OPD_NN2: r = 32'(nn_ff[2]);
         default:           r = '0;
      endcase
      return r;
   endfunction

   // multiplier stage
   rtch_pkg::step_type step;
   logic signed [31:0] opa, opb;
   logic [31:0]        ua, ub;
   logic [63:0]        pfull;
   logic [rtch_pkg::ACC_W-1:0] pmag;
   logic signed [rtch_pkg::ACC_W-1:0] prod_in;

   assign step  = rtch_pkg::prog_step(pc_ff);

   always_comb begin
      opa = pick(step.a);
      opb = pick(step.b);
   end

   assign ua    = magn(opa);
   assign ub    = magn(opb);
   assign pfull = 64'(ua) * 64'(ub);

   always_comb begin
      if (step.raw) begin
         pmag = {2'b00, pfull};
      end else begin
         pmag = {18'd0, pfull[63:rtch_pkg::FRAC]};
      end
      if (!step.raw && (opa[31] ^ opb[31])) begin
         prod_in = -$signed(pmag);
      end else begin
         prod_in = $signed(pmag);
      end
   end

   // accumulate stage
   logic signed [rtch_pkg::ACC_W-1:0] bias, base, acc_in;
   logic signed [31:0] acc_sat;

   always_comb begin
      case (ctl_ff.dst)
         rtch_pkg::DST_P0: bias = rtch_pkg::ACC_W'(o_ff[0]);
         rtch_pkg::DST_P1: bias = rtch_pkg::ACC_W'(o_ff[1]);
         rtch_pkg::DST_P2: bias = rtch_pkg::ACC_W'(o_ff[2]);
         default:          bias = '0;
      endcase
      base   = ctl_ff.first ? bias : acc_ff;
      acc_in = ctl_ff.neg ? base - prod_ff : base + prod_ff;
   end

   assign acc_sat = sat32(acc_in);

   // divider step, quotient shifts into the dividend register
   logic [32:0] rem_sh;
   logic        dge;
   logic [32:0] rem_sub;
   logic signed [31:0] dres;
   logic [14:0] dc;

   assign rem_sh  = {rem_ff, dvd_ff[47]};
   assign dge     = rem_sh >= {1'b0, dsr_ff};
   assign rem_sub = rem_sh - {1'b0, dsr_ff};
   assign dc      = dvd_ff[14:0];

   always_comb begin
      if (dneg_ff) begin
         if (dvd_ff > 48'h0000_8000_0000) begin
            dres = rtch_pkg::CMIN;
         end else begin
            dres = -$signed(dvd_ff[31:0]);
         end
      end else begin
         if (dvd_ff > 48'(rtch_pkg::CMAX)) begin
            dres = rtch_pkg::CMAX;
         end else begin
            dres = dvd_ff[31:0];
         end
      end
   end

   // square root step
   logic [63:0] strial;
   logic        sge;
   assign strial = sres_ff + sbit_ff;
   assign sge    = sx_ff >= strial;

   logic [31:0] nm [3];
   logic        nbig;
   assign nm[0] = magn(n_ff[0]);
   assign nm[1] = magn(n_ff[1]);
   assign nm[2] = magn(n_ff[2]);
   assign nbig  = nm[0][31] | nm[1][31] | nm[2][31];

   logic [31:0]        det_mag;
   logic signed [32:0] uv_sum;
   logic               req_take;
   logic               rsp_take;
   logic               rsp_load;

   assign det_mag  = magn(det_ff);
   assign uv_sum   = 33'(u_ff) + 33'(dres);
   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid_ff && !rsp_stall;
   assign rsp_load = (state_ff == ST_FINISH) && last_ff && (!rsp_valid_ff || !rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         dkind_ff      <= DK_U;
         pc_ff         <= rtch_pkg::PC_SEG_A;
         cnt_ff        <= '0;
         ctl_vld_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         best_found_ff <= 1'b0;
         tri_cnt_ff    <= '0;
         o_ff[0]       <= '0;
         o_ff[1]       <= '0;
         o_ff[2]       <= '0;
         d_ff[0]       <= '0;
         d_ff[1]       <= '0;
         d_ff[2]       <= rtch_pkg::DIR_Z_RESET;
         eps_ff        <= rtch_pkg::EPS_RESET;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               rtch_pkg::CSR_ORIGIN_X: o_ff[0] <= csr_wdata;
               rtch_pkg::CSR_ORIGIN_Y: o_ff[1] <= csr_wdata;
               rtch_pkg::CSR_ORIGIN_Z: o_ff[2] <= csr_wdata;
               rtch_pkg::CSR_DIR_X:    d_ff[0] <= csr_wdata;
               rtch_pkg::CSR_DIR_Y:    d_ff[1] <= csr_wdata;
               rtch_pkg::CSR_DIR_Z:    d_ff[2] <= csr_wdata;
               rtch_pkg::CSR_EPSILON:  eps_ff  <= csr_wdata[rtch_pkg::EPS_W-1:0];
               default: ;
            endcase
         end

         if (rsp_take && !rsp_load) begin
            rsp_valid_ff <= 1'b0;
         end

         // accumulate and write back the finished sum
         if (ctl_vld_ff) begin
            acc_ff <= acc_in;
            if (ctl_ff.last) begin
               case (ctl_ff.dst)
                  rtch_pkg::DST_H0:  h_ff[0] <= acc_sat;
                  rtch_pkg::DST_H1:  h_ff[1] <= acc_sat;
                  rtch_pkg::DST_H2:  h_ff[2] <= acc_sat;
                  rtch_pkg::DST_DET: det_ff  <= acc_sat;
                  rtch_pkg::DST_TMP: tmp_ff  <= acc_sat;
                  rtch_pkg::DST_Q0:  q_ff[0] <= acc_sat;
                  rtch_pkg::DST_Q1:  q_ff[1] <= acc_sat;
                  rtch_pkg::DST_Q2:  q_ff[2] <= acc_sat;
                  rtch_pkg::DST_N0:  n_ff[0] <= acc_sat;
                  rtch_pkg::DST_N1:  n_ff[1] <= acc_sat;
                  rtch_pkg::DST_N2:  n_ff[2] <= acc_sat;
                  rtch_pkg::DST_P0:  p_ff[0] <= acc_sat;
                  rtch_pkg::DST_P1:  p_ff[1] <= acc_sat;
                  rtch_pkg::DST_P2:  p_ff[2] <= acc_sat;
                  rtch_pkg::DST_SQ:  sq_ff   <= acc_in[63:0];
                  rtch_pkg::DST_SGN: sgn_ff  <= !acc_in[rtch_pkg::ACC_W-1] && (|acc_in);
                  default: ;
               endcase
            end
         end
         ctl_vld_ff <= (state_ff == ST_MAC);

         case (state_ff)
            ST_IDLE: begin
               if (req_take) begin
                  ea_ff[0] <= sub_sat(req_word.vert1_x, req_word.vert0_x);
                  ea_ff[1] <= sub_sat(req_word.vert1_y, req_word.vert0_y);
                  ea_ff[2] <= sub_sat(req_word.vert1_z, req_word.vert0_z);
                  eb_ff[0] <= sub_sat(req_word.vert2_x, req_word.vert0_x);
                  eb_ff[1] <= sub_sat(req_word.vert2_y, req_word.vert0_y);
                  eb_ff[2] <= sub_sat(req_word.vert2_z, req_word.vert0_z);
                  s_ff[0]  <= sub_sat(o_ff[0], req_word.vert0_x);
                  s_ff[1]  <= sub_sat(o_ff[1], req_word.vert0_y);
                  s_ff[2]  <= sub_sat(o_ff[2], req_word.vert0_z);
                  last_ff  <= req_word.last_triangle;
                  pc_ff    <= rtch_pkg::PC_SEG_A;
                  state_ff <= ST_MAC;
               end
            end
            ST_MAC: begin
               prod_ff    <= prod_in;
               ctl_ff     <= step;
               pc_ff      <= pc_ff + 1'b1;
               if (step.brk) begin
                  state_ff <= ST_WAIT;
               end
            end
            ST_WAIT: begin
               // last sum lands this cycle; pick what follows the segment
               case (pc_ff)
                  rtch_pkg::PC_SEG_B: state_ff <= ST_CHK_DET;
                  rtch_pkg::PC_SEG_C: begin
                     dkind_ff <= DK_U;
                     state_ff <= ST_DIV_LOAD;
                  end
                  rtch_pkg::PC_SEG_D: begin
                     dkind_ff <= DK_V;
                     state_ff <= ST_DIV_LOAD;
                  end
                  rtch_pkg::PC_SEG_E: begin
                     dkind_ff <= DK_T;
                     state_ff <= ST_DIV_LOAD;
                  end
                  rtch_pkg::PC_SEG_F: state_ff <= ST_NRM;
                  rtch_pkg::PC_SEG_G: state_ff <= ST_SQ_LOAD;
                  rtch_pkg::PC_END:   state_ff <= ST_COMMIT;
                  default:            state_ff <= ST_FINISH;
               endcase
            end
            ST_CHK_DET: begin
               if (det_ff == '0 || det_mag < 32'(eps_ff)) begin
                  state_ff <= ST_FINISH;
               end else begin
                  state_ff <= ST_MAC;
               end
            end
            ST_DIV_LOAD: begin
               rem_ff <= '0;
               cnt_ff <= rtch_pkg::DIV_STEPS;
               case (dkind_ff)
                  DK_N0: begin
                     dvd_ff  <= {3'b000, m_ff[0], 14'd0};
                     dsr_ff  <= len_ff;
                     dneg_ff <= 1'b0;
                  end
                  DK_N1: begin
                     dvd_ff  <= {3'b000, m_ff[1], 14'd0};
                     dsr_ff  <= len_ff;
                     dneg_ff <= 1'b0;
                  end
                  DK_N2: begin
                     dvd_ff  <= {3'b000, m_ff[2], 14'd0};
                     dsr_ff  <= len_ff;
                     dneg_ff <= 1'b0;
                  end
                  default: begin
                     dvd_ff  <= {magn(tmp_ff), 16'd0};
                     dsr_ff  <= det_mag;
                     dneg_ff <= tmp_ff[31] ^ det_ff[31];
                  end
               endcase
               state_ff <= ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
               rem_ff <= dge ? rem_sub[31:0] : rem_sh[31:0];
               dvd_ff <= {dvd_ff[46:0], dge};
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == 6'd1) begin
                  state_ff <= ST_DIV_DONE;
               end
            end
            ST_DIV_DONE: begin
               case (dkind_ff)
                  DK_U: begin
                     u_ff <= dres;
                     if (dres[31] || dres > rtch_pkg::ONE_Q) begin
                        state_ff <= ST_FINISH;
                     end else begin
                        state_ff <= ST_MAC;
                     end
                  end
                  DK_V: begin
                     if (dres[31] || uv_sum > 33'(rtch_pkg::ONE_Q)) begin
                        state_ff <= ST_FINISH;
                     end else begin
                        state_ff <= ST_MAC;
                     end
                  end
                  DK_T: begin
                     t_ff <= dres;
                     if (dres[31] || dres[30:0] < 31'(eps_ff) ||
                         (best_found_ff && dres[30:0] >= best_t_ff)) begin
                        state_ff <= ST_FINISH;
                     end else begin
                        state_ff <= ST_MAC;
                     end
                  end
                  DK_N0: begin
                     nn_ff[0] <= n_ff[0][31] ? -$signed({1'b0, dc}) : $signed({1'b0, dc});
                     dkind_ff <= DK_N1;
                     state_ff <= ST_DIV_LOAD;
                  end
                  DK_N1: begin
                     nn_ff[1] <= n_ff[1][31] ? -$signed({1'b0, dc}) : $signed({1'b0, dc});
                     dkind_ff <= DK_N2;
                     state_ff <= ST_DIV_LOAD;
                  end
                  DK_N2: begin
                     nn_ff[2] <= n_ff[2][31] ? -$signed({1'b0, dc}) : $signed({1'b0, dc});
                     state_ff <= ST_MAC;
                  end
                  default: state_ff <= ST_FINISH;
               endcase
            end
            ST_NRM: begin
               // bring every magnitude below 2^31 before squaring
               m_ff[0]  <= nbig ? nm[0][31:1] : nm[0][30:0];
               m_ff[1]  <= nbig ? nm[1][31:1] : nm[1][30:0];
               m_ff[2]  <= nbig ? nm[2][31:1] : nm[2][30:0];
               state_ff <= ST_MAC;
            end
            ST_SQ_LOAD: begin
               sx_ff    <= sq_ff;
               sres_ff  <= '0;
               sbit_ff  <= 64'h4000_0000_0000_0000;
               cnt_ff   <= rtch_pkg::SQRT_STEPS;
               state_ff <= ST_SQ_RUN;
            end
            ST_SQ_RUN: begin
               if (sge) begin
                  sx_ff   <= sx_ff - strial;
                  sres_ff <= (sres_ff >> 1) + sbit_ff;
               end else begin
                  sres_ff <= sres_ff >> 1;
               end
               sbit_ff <= sbit_ff >> 2;
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == 6'd1) begin
                  state_ff <= ST_SQ_DONE;
               end
            end
            ST_SQ_DONE: begin
               len_ff <= sres_ff[31:0];
               if (sres_ff == '0) begin
                  nn_ff[0] <= '0;
                  nn_ff[1] <= '0;
                  nn_ff[2] <= '0;
                  state_ff <= ST_MAC;
               end else begin
                  dkind_ff <= DK_N0;
                  state_ff <= ST_DIV_LOAD;
               end
            end
            ST_COMMIT: begin
               // turn the normal against the ray
               best_found_ff <= 1'b1;
               best_t_ff     <= t_ff[30:0];
               best_p_ff[0]  <= p_ff[0];
               best_p_ff[1]  <= p_ff[1];
               best_p_ff[2]  <= p_ff[2];
               best_n_ff[0]  <= sgn_ff ? -nn_ff[0] : nn_ff[0];
               best_n_ff[1]  <= sgn_ff ? -nn_ff[1] : nn_ff[1];
               best_n_ff[2]  <= sgn_ff ? -nn_ff[2] : nn_ff[2];
               best_idx_ff   <= tri_cnt_ff;
               state_ff      <= ST_FINISH;
            end
            ST_FINISH: begin
               if (!last_ff) begin
                  if (tri_cnt_ff < rtch_pkg::IDX_TOP) begin
                     tri_cnt_ff <= tri_cnt_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end else if (rsp_load) begin
                  rsp_valid_ff <= 1'b1;
                  if (best_found_ff) begin
                     rsp_word_ff.found       <= 1'b1;
                     rsp_word_ff.hit_t       <= best_t_ff;
                     rsp_word_ff.hit_point_x <= best_p_ff[0];
                     rsp_word_ff.hit_point_y <= best_p_ff[1];
                     rsp_word_ff.hit_point_z <= best_p_ff[2];
                     rsp_word_ff.normal_x    <= best_n_ff[0];
                     rsp_word_ff.normal_y    <= best_n_ff[1];
                     rsp_word_ff.normal_z    <= best_n_ff[2];
                     rsp_word_ff.hit_index   <= best_idx_ff;
                  end else begin
                     rsp_word_ff <= '0;
                  end
                  best_found_ff <= 1'b0;
                  tri_cnt_ff    <= '0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("block took a triangle and stayed ready");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_FINISH) && $past(last_ff))
      else $error("result raised outside the end of a scene");

   a_miss_is_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_word.found |-> rsp_word.hit_index == '0 && rsp_word.hit_t == '0)
      else $error("miss result carries hit data");

endmodule

// ===== test/rtch_checker.sv =====
// Closest-hit checker: watches both channels and the register port, predicts and compares.
module rtch_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_stall,
   input  rtch_pkg::req_word_type         req_word,
   input  logic                           rsp_valid,
   input  logic                           rsp_stall,
   input  rtch_pkg::rsp_word_type         rsp_word,
   input  logic                           csr_wr_en,
   input  logic [rtch_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtch_pkg::COORD_W-1:0]   csr_wdata,
   output int                             mismatches,
   output int                             outstanding
);
   import rtch_pkg::*;

   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;
   localparam longint PROD_CAP = (64'sd1 <<< 61) - 1;
   localparam longint ONE_FX = 64'sd65536;

   logic signed [COORD_W-1:0] origin [3];
   logic signed [COORD_W-1:0] dir [3];
   logic [EPS_W-1:0]          eps;

   logic                   near_found;
   logic [31:0]            near_t;
   longint                 near_point [3];
   longint                 near_normal [3];
   logic [IDX_W-1:0]       near_index;
   logic [IDX_W-1:0]       tri_count;

   rsp_word_type hit_queue [$];

   assign outstanding = hit_queue.size();

   function automatic longint clamp(input longint x);
      if (x > SAT_HI) return SAT_HI;
      if (x < SAT_LO) return SAT_LO;
      return x;
   endfunction

   function automatic longint unsigned mag(input longint x);
      return x < 0 ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint fx_mul(input longint a, input longint b);
      logic [127:0] p;
      logic [127:0] r;
      p = {64'b0, mag(a)} * {64'b0, mag(b)};
      r = p >> 16;
      if (r > 128'(PROD_CAP)) r = 128'(PROD_CAP);
      return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic longint fx_div(input longint n, input longint d);
      logic [127:0] q;
      q = ({64'b0, mag(n)} << 16) / {64'b0, mag(d)};
      if ((n < 0) != (d < 0)) begin
         if (q > 128'(SAT_HI) + 1) q = 128'(SAT_HI) + 1;
         return -longint'(q[63:0]);
      end
      if (q > 128'(SAT_HI)) q = 128'(SAT_HI);
      return longint'(q[63:0]);
   endfunction

   function automatic longint unsigned int_sqrt(input longint unsigned x);
      longint unsigned res;
      longint unsigned bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > x) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (x >= res + bitv) begin
            x = x - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint cross_part(input longint a1, input longint b2,
                                         input longint a2, input longint b1);
      return clamp(fx_mul(a1, b2) - fx_mul(a2, b1));
   endfunction

   function automatic longint dot3(input longint a0, input longint b0, input longint a1,
                                   input longint b1, input longint a2, input longint b2);
      return clamp(fx_mul(a0, b0) + fx_mul(a1, b1) + fx_mul(a2, b2));
   endfunction

   task automatic clear_nearest();
      near_found = 1'b0;
      near_t = 32'hFFFF_FFFF;
      for (int i = 0; i < 3; i++) begin
         near_point[i] = 0;
         near_normal[i] = 0;
      end
      near_index = '0;
      tri_count = '0;
   endtask

   task automatic take_triangle(input req_word_type w);
      longint o [3], d [3], p0 [3], p1 [3], p2 [3], ea [3], eb [3], s [3], h [3], q [3];
      longint n [3], nn [3];
      longint unsigned m [3], len;
      longint det, u, v, t, e;
      rsp_word_type r;
      e = longint'(eps);
      p0 = '{longint'(w.vert0_x), longint'(w.vert0_y), longint'(w.vert0_z)};
      p1 = '{longint'(w.vert1_x), longint'(w.vert1_y), longint'(w.vert1_z)};
      p2 = '{longint'(w.vert2_x), longint'(w.vert2_y), longint'(w.vert2_z)};
      for (int i = 0; i < 3; i++) begin
         o[i] = longint'(origin[i]);
         d[i] = longint'(dir[i]);
         ea[i] = clamp(p1[i] - p0[i]);
         eb[i] = clamp(p2[i] - p0[i]);
         s[i] = clamp(o[i] - p0[i]);
      end
      h[0] = cross_part(d[1], eb[2], d[2], eb[1]);
      h[1] = cross_part(d[2], eb[0], d[0], eb[2]);
      h[2] = cross_part(d[0], eb[1], d[1], eb[0]);
      det = dot3(ea[0], h[0], ea[1], h[1], ea[2], h[2]);
      if (det != 0 && longint'(mag(det)) >= e) begin
         u = fx_div(dot3(s[0], h[0], s[1], h[1], s[2], h[2]), det);
         if (u >= 0 && u <= ONE_FX) begin
            q[0] = cross_part(s[1], ea[2], s[2], ea[1]);
            q[1] = cross_part(s[2], ea[0], s[0], ea[2]);
            q[2] = cross_part(s[0], ea[1], s[1], ea[0]);
            v = fx_div(dot3(d[0], q[0], d[1], q[1], d[2], q[2]), det);
            if (v >= 0 && u + v <= ONE_FX) begin
               t = fx_div(dot3(eb[0], q[0], eb[1], q[1], eb[2], q[2]), det);
               if (t >= e && (!near_found || t < longint'({32'b0, near_t}))) begin
                  n[0] = cross_part(ea[1], eb[2], ea[2], eb[1]);
                  n[1] = cross_part(ea[2], eb[0], ea[0], eb[2]);
                  n[2] = cross_part(ea[0], eb[1], ea[1], eb[0]);
                  for (int i = 0; i < 3; i++) m[i] = mag(n[i]);
                  while ((m[0] | m[1] | m[2]) >= (64'd1 << 31)) begin
                     for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
                  end
                  len = int_sqrt(m[0] * m[0] + m[1] * m[1] + m[2] * m[2]);
                  for (int i = 0; i < 3; i++) begin
                     nn[i] = (len != 0) ? longint'((m[i] << NFRAC) / len) : 0;
                     if (n[i] < 0) nn[i] = -nn[i];
                  end
                  // turn the normal to face against the ray
                  if (fx_mul(nn[0], d[0]) + fx_mul(nn[1], d[1]) + fx_mul(nn[2], d[2]) > 0)
                     for (int i = 0; i < 3; i++) nn[i] = -nn[i];
                  near_found = 1'b1;
                  near_t = t[31:0];
                  for (int i = 0; i < 3; i++) begin
                     near_point[i] = clamp(o[i] + fx_mul(t, d[i]));
                     near_normal[i] = nn[i];
                  end
                  near_index = tri_count;
               end
            end
         end
      end
      if (tri_count != IDX_TOP) tri_count = tri_count + 1'b1;
      if (w.last_triangle) begin
         r = '0;
         if (near_found) begin
            r.found = 1'b1;
            r.hit_t = near_t[COORD_W-2:0];
            r.hit_point_x = near_point[0][COORD_W-1:0];
            r.hit_point_y = near_point[1][COORD_W-1:0];
            r.hit_point_z = near_point[2][COORD_W-1:0];
            r.normal_x = near_normal[0][NORMAL_W-1:0];
            r.normal_y = near_normal[1][NORMAL_W-1:0];
            r.normal_z = near_normal[2][NORMAL_W-1:0];
            r.hit_index = near_index;
         end
         hit_queue.push_back(r);
         clear_nearest();
      end
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %h, got %h", name, want, got);
      end
   endtask

   task automatic check_hit(input rsp_word_type got);
      rsp_word_type want;
      if (hit_queue.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result word %p", got);
      end else begin
         want = hit_queue.pop_front();
         check_field("found", 64'(want.found), 64'(got.found));
         check_field("hit_t", 64'(want.hit_t), 64'(got.hit_t));
         check_field("hit_point_x", 64'(want.hit_point_x), 64'(got.hit_point_x));
         check_field("hit_point_y", 64'(want.hit_point_y), 64'(got.hit_point_y));
         check_field("hit_point_z", 64'(want.hit_point_z), 64'(got.hit_point_z));
         check_field("normal_x", 64'(want.normal_x), 64'(got.normal_x));
         check_field("normal_y", 64'(want.normal_y), 64'(got.normal_y));
         check_field("normal_z", 64'(want.normal_z), 64'(got.normal_z));
         check_field("hit_index", 64'(want.hit_index), 64'(got.hit_index));
      end
   endtask

   initial mismatches = 0;

   always @(posedge clock) begin
      if (reset) begin
         origin = '{default: '0};
         dir = '{'0, '0, DIR_Z_RESET};
         eps = EPS_RESET;
         clear_nearest();
         hit_queue.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_ORIGIN_X: origin[0] = csr_wdata;
               CSR_ORIGIN_Y: origin[1] = csr_wdata;
               CSR_ORIGIN_Z: origin[2] = csr_wdata;
               CSR_DIR_X:    dir[0] = csr_wdata;
               CSR_DIR_Y:    dir[1] = csr_wdata;
               CSR_DIR_Z:    dir[2] = csr_wdata;
               CSR_EPSILON:  eps = csr_wdata[EPS_W-1:0];
               default: ;
            endcase
         end
         // retire the older result before queuing a new one
         if (rsp_valid && !rsp_stall) check_hit(rsp_word);
         if (req_valid && !req_stall) take_triangle(req_word);
      end
   end
endmodule

// ===== test/testbench.sv =====
// Top of the closest-hit testbench: clock, reset, register writes, triangle stimulus, verdict.
module testbench;
   import rtch_pkg::*;

   localparam int STALL_LIMIT = 20000;
   localparam int DRAIN_WAIT = 450;
   localparam longint Q = 65536;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_word_type req_word;
   logic rsp_valid;
   logic rsp_stall;
   rsp_word_type rsp_word;
   logic csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [COORD_W-1:0] csr_wdata;
   int mismatches;
   int outstanding;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   longint ray_o [3];
   longint ray_d [3];

   ray_triangle_closest_hit dut (.*);

   rtch_checker checker_inst (.*);

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   always @(posedge clock) rsp_stall <= ($urandom_range(99) < recv_stall_pct);

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   function automatic req_word_type make_tri(input longint a [9], input logic last);
      req_word_type w;
      w = {a[0][31:0], a[1][31:0], a[2][31:0], a[3][31:0], a[4][31:0], a[5][31:0],
           a[6][31:0], a[7][31:0], a[8][31:0], last};
      return w;
   endfunction

   task automatic send_tri(input req_word_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_q(input longint a [9], input logic last);
      send_tri(make_tri(a, last));
   endtask

   // hold the sender until every result is out, then let the block settle
   task automatic drain();
      req_valid <= 1'b0;
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic load_ray(input longint o [3], input longint d [3], input logic [15:0] e);
      logic [31:0] vals [7];
      vals = '{o[0][31:0], o[1][31:0], o[2][31:0], d[0][31:0], d[1][31:0], d[2][31:0],
               {16'b0, e}};
      ray_o = o;
      ray_d = d;
      for (int i = 0; i < 7; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_IDX_W'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      // an index past the last register must be dropped
      csr_index <= CSR_EPSILON + 1'b1;
      csr_wdata <= $urandom;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic req_word_type random_tri(input logic last);
      longint a [9];
      longint p [3];
      longint t;
      int kind;
      kind = $urandom_range(99);
      t = $urandom_range(8 * Q, Q / 4);
      for (int i = 0; i < 3; i++) p[i] = ray_o[i] + ((t * ray_d[i]) >>> 16);
      for (int k = 0; k < 9; k++) begin
         if (kind < 75)
            a[k] = p[k % 3] + longint'($urandom_range(1 << 19)) - (1 << 18);
         else
            a[k] = longint'($signed($urandom));
      end
      if (kind >= 90) begin
         a[3] = a[0]; a[4] = a[1]; a[5] = a[2];
      end
      return make_tri(a, last);
   endfunction

   function automatic longint rnd_coord(input int span);
      return longint'($urandom_range(2 * span)) - span;
   endfunction

   task automatic random_run(input int count);
      int left;
      left = $urandom_range(8, 1);
      for (int i = 0; i < count; i++) begin
         left--;
         send_tri(random_tri(left == 0 || i == count - 1));
         if (left == 0) left = $urandom_range(8, 1);
      end
      drain();
   endtask

   initial begin
      longint o [3], d [3];
      reset = 1'b1;
      req_valid = 1'b0;
      req_word = '0;
      rsp_stall = 1'b0;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      quiet_cycles = 0;
      ray_o = '{0, 0, 0};
      ray_d = '{0, 0, Q};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset ray: origin zero, looking along +z, epsilon one lsb
      send_q('{-Q, -Q, 5*Q, 2*Q, -Q, 5*Q, -Q, 2*Q, 5*Q}, 1'b1);
      send_q('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b1);
      send_q('{-Q, -Q, -5*Q, 2*Q, -Q, -5*Q, -Q, 2*Q, -5*Q}, 1'b0);
      send_q('{Q, -Q, 4*Q, 3*Q, -Q, 4*Q, Q, 2*Q, 4*Q}, 1'b0);
      send_q('{-Q, Q/2, 4*Q, Q, Q/2, 4*Q, -Q, 3*Q, 4*Q}, 1'b0);
      send_q('{-Q, -Q, 3*Q, 2*Q, -Q, 3*Q, -Q, 2*Q, 3*Q}, 1'b0);
      send_q('{-Q, -Q, 3*Q, 2*Q, -Q, 3*Q, -Q, 2*Q, 3*Q}, 1'b0);
      send_q('{-Q, -Q, 2*Q, -Q, 2*Q, 2*Q, 2*Q, -Q, 2*Q}, 1'b1);
      send_q('{0, 0, 0, 0, 0, Q, Q, 0, Q}, 1'b1);
      send_q('{2147483647, 2147483647, 2147483647, -2147483648, -2147483648,
               -2147483648, 2147483647, -2147483648, 2147483647}, 1'b0);
      send_q('{-2147483648, -2147483648, 1, 2147483647, -2147483648, 1,
               -2147483648, 2147483647, 1}, 1'b0);
      send_q('{-2147483648, -2147483648, -2147483648, -2147483648, -2147483648,
               -2147483648, -2147483648, -2147483648, -2147483648}, 1'b1);
      drain();
      // zero determinant with zero tolerance, then a huge tolerance
      load_ray('{0, 0, 0}, '{0, 0, Q}, 16'h0000);
      send_q('{0, 0, Q, 0, 0, Q, 0, 0, Q}, 1'b0);
      send_q('{-Q, -Q, Q/2, Q, -Q, Q/2, -Q, Q, Q/2}, 1'b1);
      drain();
      load_ray('{2147483647, -2147483648, 2147483647},
               '{-2147483648, 2147483647, -2147483648}, 16'hFFFF);
      send_q('{-Q, -Q, 5*Q, 2*Q, -Q, 5*Q, -Q, 2*Q, 5*Q}, 1'b0);
      send_q('{0, 0, 0, 2147483647, 0, 0, 0, 2147483647, 0}, 1'b1);
      drain();

      for (int regime = 0; regime < 3; regime++) begin
         send_idle_pct = (regime == 0) ? 21 : (regime == 1) ? 66 : 0;
         recv_stall_pct = (regime == 0) ? 66 : (regime == 1) ? 21 : 0;
         for (int k = 0; k < 6; k++) begin
            for (int i = 0; i < 3; i++) begin
               o[i] = rnd_coord(1 << 20);
               d[i] = rnd_coord(1 << 17);
            end
            if (d[2] > Q) d[2] = Q;
            load_ray(o, d, (k == 0) ? 16'h0000 : (k == 1) ? 16'hFFFF
                                     : 16'($urandom_range(64)));
            random_run(44);
         end
      end

      // advance the index with degenerate triangles, then hit once
      send_idle_pct = 0;
      recv_stall_pct = 0;
      load_ray('{0, 0, 0}, '{0, 0, Q}, 16'h0001);
      for (int i = 0; i < 8; i++) send_q('{0, 0, 0, 0, 0, 0, 0, 0, 0}, 1'b0);
      send_q('{-Q, -Q, 5*Q, 2*Q, -Q, 5*Q, -Q, 2*Q, 5*Q}, 1'b1);
      drain();

      if (mismatches == 0 && outstanding == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

// ===== sim.f =====
design/rtch_pkg.sv
design/ray_triangle_closest_hit.sv
test/rtch_checker.sv
test/testbench.sv
